[hw/rtl/ibds_pkg.sv]
// Shared types and the SCL divider table for the baud divider search.
package ibds_pkg;

  localparam int TABLE_SIZE  = 64;
  localparam int IDX_W       = 6;
  localparam int DIV_W       = 12;
  localparam int TARGET_W    = 22;
  localparam int CLOCK_W     = 32;
  localparam int RATE_W      = 28;
  localparam int CODE_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int BITCNT_W    = 5;

  localparam logic [CODE_W-1:0] MULT_X1 = 2'd0;
  localparam logic [CODE_W-1:0] MULT_X2 = 2'd1;
  localparam logic [CODE_W-1:0] MULT_X4 = 2'd2;

  localparam logic [DIV_W-1:0] SCL_DIV [TABLE_SIZE] = '{
    12'd20,   12'd22,   12'd24,   12'd26,   12'd28,   12'd30,   12'd34,   12'd40,
    12'd28,   12'd32,   12'd36,   12'd40,   12'd44,   12'd48,   12'd56,   12'd68,
    12'd48,   12'd56,   12'd64,   12'd72,   12'd80,   12'd88,   12'd104,  12'd128,
    12'd80,   12'd96,   12'd112,  12'd128,  12'd144,  12'd160,  12'd192,  12'd240,
    12'd160,  12'd192,  12'd224,  12'd256,  12'd288,  12'd320,  12'd384,  12'd480,
    12'd320,  12'd384,  12'd448,  12'd512,  12'd576,  12'd640,  12'd768,  12'd960,
    12'd640,  12'd768,  12'd896,  12'd1024, 12'd1152, 12'd1280, 12'd1536, 12'd1920,
    12'd1280, 12'd1536, 12'd1792, 12'd2048, 12'd2304, 12'd2560, 12'd3072, 12'd3840
  };

  typedef struct packed {
    logic              load_in;
    logic              div_start;
    logic              div_step;
    logic              cmp_en;
    logic [CODE_W-1:0] cmp_sel;
    logic              next_entry;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic last_entry;
  } status_t;

endpackage

[hw/rtl/ibds_datapath.sv]
// Datapath: serial divider, distance compare, best-pair tracking and result registers.
module ibds_datapath #(
  parameter int DIVIDER_ENTRIES = 64
) (
  input  logic                            clk,
  input  ibds_pkg::cmd_t                  cmd,
  output ibds_pkg::status_t               status,
  input  logic [ibds_pkg::TARGET_W-1:0]   target_rate,
  input  logic [ibds_pkg::CLOCK_W-1:0]    module_clock,
  output logic [ibds_pkg::CODE_W-1:0]     mult_code,
  output logic [ibds_pkg::IDX_W-1:0]      divider_index,
  output logic [ibds_pkg::RATE_W-1:0]     achieved_rate,
  output logic [ibds_pkg::BYTE_W-1:0]     freq_reg_byte
);

  localparam logic [ibds_pkg::IDX_W-1:0] LAST_IDX = ibds_pkg::IDX_W'(DIVIDER_ENTRIES - 1);

  logic [ibds_pkg::TARGET_W-1:0] target_r;
  logic [ibds_pkg::CLOCK_W-1:0]  clock_r;
  logic [ibds_pkg::IDX_W-1:0]    idx_r;
  logic [ibds_pkg::DIV_W-1:0]    divisor_r;
  logic [ibds_pkg::DIV_W-1:0]    rem_r, rem_nxt;
  logic [ibds_pkg::CLOCK_W-1:0]  quo_r, quo_nxt;
  logic [ibds_pkg::BITCNT_W-1:0] cnt_r;
  logic [ibds_pkg::RATE_W-1:0]   best_dist_r, best_rate_r;
  logic [ibds_pkg::CODE_W-1:0]   best_mult_r;
  logic [ibds_pkg::IDX_W-1:0]    best_idx_r;
  logic [ibds_pkg::CODE_W-1:0]   mult_r;
  logic [ibds_pkg::IDX_W-1:0]    index_r;
  logic [ibds_pkg::RATE_W-1:0]   rate_r;

  logic [ibds_pkg::DIV_W:0]      trial;
  logic                          qbit;
  logic [ibds_pkg::CLOCK_W-1:0]  shifted;
  logic [ibds_pkg::RATE_W-1:0]   cand_rate, cand_dist, target_ext;
  logic                          better;

  always_comb begin
    trial   = {rem_r, quo_r[ibds_pkg::CLOCK_W-1]};
    qbit    = (trial >= {1'b0, divisor_r});
    rem_nxt = qbit ? ibds_pkg::DIV_W'(trial - {1'b0, divisor_r})
                   : trial[ibds_pkg::DIV_W-1:0];
    quo_nxt = {quo_r[ibds_pkg::CLOCK_W-2:0], qbit};
  end

  always_comb begin
    shifted    = quo_r >> cmd.cmp_sel;
    cand_rate  = shifted[ibds_pkg::RATE_W-1:0];
    target_ext = ibds_pkg::RATE_W'(target_r);
    cand_dist  = (target_ext >= cand_rate) ? (target_ext - cand_rate) : (cand_rate - target_ext);
    better     = (cand_dist < best_dist_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      target_r    <= target_rate;
      clock_r     <= module_clock;
      idx_r       <= '0;
      best_dist_r <= ibds_pkg::RATE_W'(target_rate);
      best_rate_r <= '0;
      best_mult_r <= ibds_pkg::MULT_X1;
      best_idx_r  <= '0;
    end
    if (cmd.div_start) begin
      divisor_r <= ibds_pkg::SCL_DIV[idx_r];
      rem_r     <= '0;
      quo_r     <= clock_r;
      cnt_r     <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.cmp_en && better) begin
      best_dist_r <= cand_dist;
      best_rate_r <= cand_rate;
      best_mult_r <= cmd.cmp_sel;
      best_idx_r  <= idx_r;
    end
    if (cmd.next_entry) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.load_out) begin
      mult_r  <= best_mult_r;
      index_r <= best_idx_r;
      rate_r  <= best_rate_r;
    end
  end

  assign status.div_last   = (cnt_r == '1);
  assign status.last_entry = (idx_r == LAST_IDX);

  assign mult_code     = mult_r;
  assign divider_index = index_r;
  assign achieved_rate = rate_r;
  assign freq_reg_byte = {mult_r, index_r};

endmodule

[hw/rtl/ibds_ctrl.sv]
// Controller: sequences divisions and compares over the table and owns both handshakes.
module ibds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ibds_pkg::cmd_t    cmd,
  input  ibds_pkg::status_t status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CMP0  = 3'd3;
  localparam logic [2:0] S_CMP1  = 3'd4;
  localparam logic [2:0] S_CMP2  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_CMP0;
        end
      end
      S_CMP0: begin
        cmd.cmp_en  = 1'b1;
        cmd.cmp_sel = ibds_pkg::MULT_X1;
        state_nxt   = S_CMP1;
      end
      S_CMP1: begin
        cmd.cmp_en  = 1'b1;
        cmd.cmp_sel = ibds_pkg::MULT_X2;
        state_nxt   = S_CMP2;
      end
      S_CMP2: begin
        cmd.cmp_en  = 1'b1;
        cmd.cmp_sel = ibds_pkg::MULT_X4;
        if (status.last_entry) begin
          state_nxt = S_DONE;
        end else begin
          cmd.next_entry = 1'b1;
          state_nxt      = S_START;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hw/rtl/i2c_baud_divider_search_core.sv]
// Top level of the nearest SCL divider search: controller plus datapath.
// Each entry takes one 32-step restoring division of the clock by the table divider,
// then three compares for x1, x2, x4 taken as shifts of that quotient.
// Items are taken one at a time, as in_ready is high only in idle; a new item is taken while a result waits.
// Reset (synchronous, active low) clears the controller state and the output valid flag.
module i2c_baud_divider_search_core #(
  parameter int DIVIDER_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ibds_pkg::TARGET_W-1:0]   in_target_rate,
  input  logic [ibds_pkg::CLOCK_W-1:0]    in_module_clock,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ibds_pkg::CODE_W-1:0]     out_mult_code,
  output logic [ibds_pkg::IDX_W-1:0]      out_divider_index,
  output logic [ibds_pkg::RATE_W-1:0]     out_achieved_rate,
  output logic [ibds_pkg::BYTE_W-1:0]     out_freq_reg_byte
);

  ibds_pkg::cmd_t    cmd;
  ibds_pkg::status_t status;

  ibds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  ibds_datapath #(
    .DIVIDER_ENTRIES (DIVIDER_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .target_rate   (in_target_rate),
    .module_clock  (in_module_clock),
    .mult_code     (out_mult_code),
    .divider_index (out_divider_index),
    .achieved_rate (out_achieved_rate),
    .freq_reg_byte (out_freq_reg_byte)
  );

endmodule
